@@ sv/kdm_pkg.sv @@
// shared types, codes and defaults for the key to dense id hash map
`default_nettype none

package kdm_pkg;

    localparam int SLOTS_DEF    = 1024;
    localparam int MAX_IDS_DEF  = 512;
    localparam int KEY_BITS_DEF = 64;

    localparam int KEY_PORT_W = 64;
    localparam int ID_W       = 9;
    localparam int STATUS_W   = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT_RD,
        S_KEY_RD,
        S_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

@@ sv/kdm_hash.sv @@
// start slot of the probe: xor fold of the key reduced below the slot count
`default_nettype none

module kdm_hash #(
    parameter int SLOTS    = 1024,
    parameter int KEY_BITS = 64
) (
    input  wire logic [KEY_BITS-1:0]        key,
    output logic      [$clog2(SLOTS)-1:0]   idx
);

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int CHUNKS    = (KEY_BITS + SLOT_BITS - 1) / SLOT_BITS;
    localparam int PAD_W     = CHUNKS * SLOT_BITS;

    logic [PAD_W-1:0]     key_pad;
    logic [SLOT_BITS-1:0] fold;

    assign key_pad = PAD_W'(key);

    always_comb
    begin
        fold = '0;
        for (int c = 0; c < CHUNKS; c++)
        begin
            fold = fold ^ key_pad[c*SLOT_BITS +: SLOT_BITS];
        end
    end

    always_comb
    begin
        if ({1'b0, fold} >= (SLOT_BITS+1)'(SLOTS))
        begin
            idx = fold - SLOT_BITS'(SLOTS);
        end
        else
        begin
            idx = fold;
        end
    end

endmodule

`default_nettype wire

@@ sv/key_to_dense_id_hash_map_top.sv @@
// key to dense id hash map: linear probe sequencer, slot table and key store
// each probe reads the slot, then the key, then compares; a probe that meets an
// empty slot ends after the key read; a request is accepted in idle and its result
// is moved to the output register in done; only one request is in flight at a time
// a finished result waits in the output register while the next request is taken
// reset: next id cleared, then a clearing pass over all SLOTS slots (1024 by default)
// empties the slot table; requests are stalled until it ends
`default_nettype none

module key_to_dense_id_hash_map_top
    import kdm_pkg::*;
#(
    parameter int SLOTS    = kdm_pkg::SLOTS_DEF,
    parameter int MAX_IDS  = kdm_pkg::MAX_IDS_DEF,
    parameter int KEY_BITS = kdm_pkg::KEY_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [kdm_pkg::KEY_PORT_W-1:0]  key,
    input  wire logic                            create,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [kdm_pkg::ID_W-1:0]        id,
    output logic      [kdm_pkg::STATUS_W-1:0]    status
);

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int ID_LIMIT  = (MAX_IDS < SLOTS / 2) ? MAX_IDS : SLOTS / 2;
    localparam int IDX_W     = $clog2(ID_LIMIT);
    localparam int NID_W     = $clog2(ID_LIMIT + 1);
    localparam int SLOT_W    = IDX_W + 1;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);
    localparam logic [NID_W-1:0]     NID_LIMIT = NID_W'(ID_LIMIT);

    state_t state_reg, state_next;

    logic [SLOT_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic                 create_reg, create_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic [SLOT_BITS-1:0] probe_cnt_reg, probe_cnt_next;
    logic [NID_W-1:0]     next_id_reg, next_id_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    status_t              res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ID_W-1:0]      id_reg, id_next;
    status_t              status_reg, status_next;

    logic [SLOT_W-1:0]    slot_mem [SLOTS];
    logic [KEY_BITS-1:0]  key_mem [ID_LIMIT];
    logic [SLOT_W-1:0]    slot_rd_reg;
    logic [KEY_BITS-1:0]  key_rd_reg;

    logic                 slot_we;
    logic [SLOT_BITS-1:0] slot_waddr;
    logic [SLOT_W-1:0]    slot_wdata;
    logic                 key_we;

    logic [KEY_BITS-1:0]  key_in;
    logic [SLOT_BITS-1:0] hash_idx;
    logic                 accept;
    logic                 out_free;
    logic                 slot_used;
    logic [IDX_W-1:0]     slot_id;
    logic                 key_match;
    logic                 room;

    assign key_in    = key[KEY_BITS-1:0];
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign slot_used = slot_rd_reg[SLOT_W-1];
    assign slot_id   = slot_rd_reg[IDX_W-1:0];
    assign key_match = (key_rd_reg == key_reg);
    assign room      = (next_id_reg < NID_LIMIT);

    kdm_hash #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_hash (
        .key (key_in),
        .idx (hash_idx)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SLOT_RD;
                end
            end
            S_SLOT_RD:
            begin
                state_next = S_KEY_RD;
            end
            S_KEY_RD:
            begin
                state_next = slot_used ? S_CMP : S_DONE;
            end
            S_CMP:
            begin
                if (key_match || (probe_cnt_reg == LAST_SLOT))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SLOT_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_stall        = (state_reg != S_IDLE);
        clr_cnt_next    = clr_cnt_reg;
        key_next        = key_reg;
        create_next     = create_reg;
        idx_next        = idx_reg;
        probe_cnt_next  = probe_cnt_reg;
        next_id_next    = next_id_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        id_next         = id_reg;
        status_next     = status_reg;
        slot_we         = 1'b0;
        slot_waddr      = idx_reg;
        slot_wdata      = '0;
        key_we          = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we      = 1'b1;
                slot_waddr   = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next       = key_in;
                    create_next    = create;
                    idx_next       = hash_idx;
                    probe_cnt_next = '0;
                end
            end
            S_SLOT_RD:
            begin
            end
            S_KEY_RD:
            begin
                if (!slot_used)
                begin
                    res_id_next = '0;
                    if (!create_reg)
                    begin
                        res_status_next = ST_ABSENT;
                    end
                    else if (room)
                    begin
                        slot_we         = 1'b1;
                        slot_wdata      = {1'b1, next_id_reg[IDX_W-1:0]};
                        key_we          = 1'b1;
                        res_id_next     = ID_W'(next_id_reg);
                        res_status_next = ST_INSERTED;
                        next_id_next    = next_id_reg + 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                end
            end
            S_CMP:
            begin
                if (key_match)
                begin
                    res_id_next     = ID_W'(slot_id);
                    res_status_next = ST_FOUND;
                end
                else if (probe_cnt_reg == LAST_SLOT)
                begin
                    res_id_next     = '0;
                    res_status_next = create_reg ? ST_FULL : ST_ABSENT;
                end
                else
                begin
                    idx_next       = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    id_next        = res_id_reg;
                    status_next    = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        create_reg     <= create_next;
        idx_reg        <= idx_next;
        probe_cnt_reg  <= probe_cnt_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        id_reg         <= id_next;
        status_reg     <= status_next;
    end

    // slot table
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[idx_reg];
    end

    // key store
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[next_id_reg[IDX_W-1:0]] <= key_reg;
        end
        key_rd_reg <= key_mem[slot_id];
    end

    assign out_valid = out_valid_reg;
    assign id        = id_reg;
    assign status    = status_reg;

    a_next_id_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg <= NID_LIMIT)
        else $error("id count beyond limit");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result shown without a finished request");

    a_cmp_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |=> (state_reg == S_DONE || state_reg == S_SLOT_RD))
        else $error("compare left to a wrong state");

    a_full_needs_create: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_status_reg == ST_FULL) |-> create_reg)
        else $error("full status on a lookup");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |=> (next_id_reg == $past(next_id_reg) + 1'b1))
        else $error("insert did not advance the id count");

endmodule

`default_nettype wire

@@ sim/key_to_dense_id_hash_map_top_tb.sv @@
// testbench for the key to dense id hash map: random and directed requests with a scoreboard
module key_to_dense_id_hash_map_top_tb;
    import kdm_pkg::*;

    localparam int ID_LIMIT = (MAX_IDS_DEF < SLOTS_DEF / 2) ? MAX_IDS_DEF : SLOTS_DEF / 2;
    localparam logic [KEY_PORT_W-1:0] KEY_MASK =
        {KEY_PORT_W{1'b1}} >> (KEY_PORT_W - KEY_BITS_DEF);
    localparam int RANDOM_PER_PHASE = 300;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [ID_W-1:0] id;
        status_t         status;
    } map_result_t;

    class id_map_scoreboard;
        logic [ID_W-1:0] id_of_key [logic [KEY_PORT_W-1:0]];
        int unsigned     ids_issued;
        map_result_t     pending_results [$];
        int unsigned     errors;

        task report(string msg);
            errors++;
            $display("tb: mismatch: %s", msg);
        endtask

        function int pending();
            return pending_results.size();
        endfunction

        function void note_request(logic [KEY_PORT_W-1:0] key_in, logic create_in);
            logic [KEY_PORT_W-1:0] k;
            map_result_t           r;
            k = key_in & KEY_MASK;
            r.id = '0;
            if (id_of_key.exists(k))
            begin
                r.id = id_of_key[k];
                r.status = ST_FOUND;
            end
            else if (!create_in)
            begin
                r.status = ST_ABSENT;
            end
            else if (ids_issued < ID_LIMIT)
            begin
                r.id = ids_issued[ID_W-1:0];
                r.status = ST_INSERTED;
                id_of_key[k] = r.id;
                ids_issued++;
            end
            else
            begin
                r.status = ST_FULL;
            end
            pending_results.push_back(r);
        endfunction

        task check_result(logic [ID_W-1:0] got_id, logic [STATUS_W-1:0] got_status);
            map_result_t r;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result id %0d status %0d with no request pending",
                                 got_id, got_status));
            end
            else
            begin
                r = pending_results.pop_front();
                if (got_id !== r.id)
                    report($sformatf("id got %0d want %0d", got_id, r.id));
                if (got_status !== r.status)
                    report($sformatf("status got %0d want %0d", got_status, r.status));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [KEY_PORT_W-1:0] key;
    logic                  create;
    logic                  out_valid;
    logic                  out_stall;
    logic [ID_W-1:0]       id;
    logic [STATUS_W-1:0]   status;

    int unsigned           send_idle_pct;
    int unsigned           stall_pct;
    logic                  hold_go;
    logic                  hold_on;
    logic [KEY_PORT_W-1:0] used_keys [$];
    id_map_scoreboard      sb;

    key_to_dense_id_hash_map_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .key       (key),
        .create    (create),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .id        (id),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // long output hold-off so the block backs up onto its input
    initial
    begin
        hold_on = 1'b0;
        wait (hold_go === 1'b1);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(id, status);
    end

    task automatic send_request(input logic [KEY_PORT_W-1:0] k, input logic c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key      <= k;
        create   <= c;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(k, c);
        if (c)
            used_keys.push_back(k);
    endtask

    task automatic send_random_request();
        int unsigned           pick;
        logic [KEY_PORT_W-1:0] k;
        pick = $urandom_range(0, 99);
        k = {$urandom, $urandom};
        if (pick < 50)
            send_request(k, 1'b1);
        else if (pick < 80 && used_keys.size() != 0)
            send_request(used_keys[$urandom_range(0, used_keys.size() - 1)],
                         1'($urandom_range(0, 1)));
        else
            send_request(k, 1'b0);
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_go = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        key = '0;
        create = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme keys, found, inserted and absent outcomes, create on an existing key
        send_request(64'h0, 1'b0);
        send_request(64'h0, 1'b1);
        send_request(64'h0, 1'b0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_request(64'h0, 1'b1);
        send_request(64'h8000_0000_0000_0000, 1'b1);
        send_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(64'h1, 1'b0);
        send_request(64'h1, 1'b1);
        send_request(64'h5555_5555_5555_5555, 1'b1);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_request(64'h5555_5555_5555_5555, 1'b0);
        send_request(64'h8000_0000_0000_0000, 1'b0);
        send_request(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    hold_go = 1'b1;
                end
                1:
                begin
                    send_idle_pct = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct = 17;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_random_request();
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
